// ===== hw/rtl/rtnh_pkg.sv =====
// Shared types, constants and the sequencer program for the ray/triangle nearest-hit block.
// Used by rtnh_mac, rtnh_div and ray_triangle_nearest_hit; no dependencies of its own.
`timescale 1ns / 1ps
package rtnh_pkg;

  localparam int CRD_W   = 32;   // Q16.16 coordinate
  localparam int DIFF_W  = 33;   // difference of two coordinates
  localparam int SLOT_W  = 68;   // scratch slot, holds a cross product component
  localparam int ACC_W   = 137;  // accumulator, holds a dot of two cross products
  localparam int NUM_W   = 103;  // plane numerator and denominator
  localparam int DIV_W   = 134;  // divider remainder and shifted divisor
  localparam int Q_W     = 31;   // quotient t, unsigned Q15.16
  localparam int DIST_W  = 31;
  localparam int PC_W    = 7;
  localparam int SLOT_AW = 4;
  localparam int STEP_W  = 7;
  localparam int QCNT_W  = 5;
  localparam int CFG_AW  = 3;

  localparam logic [DIST_W-1:0]  MISS_DIST   = '1;
  localparam logic [Q_W-1:0]     Q_SAT       = '1;
  localparam logic [PC_W-1:0]    EDGE_PC     = 7'd35;
  localparam logic [SLOT_AW-1:0] Q_SLOT      = 4'd15;
  localparam logic [STEP_W-1:0]  NARROW_LAST = 7'd32;
  localparam logic [STEP_W-1:0]  WIDE_LAST   = 7'd67;

  localparam logic [CFG_AW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DIR_Z    = 3'd5;

  typedef enum logic [2:0] {
    UK_LOAD, UK_MAC, UK_STORE, UK_SVNUM, UK_DIV, UK_PNT, UK_SIDE, UK_HIT
  } uop_kind_t;

  typedef enum logic [3:0] {
    PT_A, PT_B, PT_C, PT_P, PT_O, PT_D, PT_Z, PT_BASE, PT_END, PT_OPP
  } pt_t;

  typedef struct packed {
    uop_kind_t           kind;
    logic [SLOT_AW-1:0]  sa;
    logic [SLOT_AW-1:0]  sb;
    logic [SLOT_AW-1:0]  dst;
    pt_t                 pm;
    pt_t                 ps;
    logic [1:0]          comp;
    logic                wide;
    logic                neg;
    logic                clr;
  } uop_t;

  typedef struct packed {
    logic start;
    logic clr;
    logic neg;
    logic wide;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

  typedef enum logic [2:0] {SQ_IDLE, SQ_FETCH, SQ_EXEC, SQ_WAIT, SQ_OUT} seq_state_t;
  typedef enum logic [1:0] {DV_IDLE, DV_CHK, DV_RUN} div_state_t;

  function automatic uop_t u_load(logic [SLOT_AW-1:0] dst, pt_t m, pt_t s, logic [1:0] comp);
    uop_t u;
    u = '0;
    u.kind = UK_LOAD;
    u.dst  = dst;
    u.pm   = m;
    u.ps   = s;
    u.comp = comp;
    return u;
  endfunction

  function automatic uop_t u_mac(logic [SLOT_AW-1:0] sa, logic [SLOT_AW-1:0] sb,
                                 logic wide, logic neg, logic clr);
    uop_t u;
    u = '0;
    u.kind = UK_MAC;
    u.sa   = sa;
    u.sb   = sb;
    u.wide = wide;
    u.neg  = neg;
    u.clr  = clr;
    return u;
  endfunction

  function automatic uop_t u_ctl(uop_kind_t kind, logic [SLOT_AW-1:0] dst, logic [1:0] comp);
    uop_t u;
    u = '0;
    u.kind = kind;
    u.dst  = dst;
    u.comp = comp;
    return u;
  endfunction

  // Cross product of slots 0..2 by slots 3..5 into three slots from dst.
  function automatic uop_t u_cross(logic [3:0] k, logic [SLOT_AW-1:0] dst);
    uop_t u;
    case (k)
      4'd0:    u = u_mac(4'd1, 4'd5, 1'b0, 1'b0, 1'b1);
      4'd1:    u = u_mac(4'd2, 4'd4, 1'b0, 1'b1, 1'b0);
      4'd2:    u = u_ctl(UK_STORE, dst, 2'd0);
      4'd3:    u = u_mac(4'd2, 4'd3, 1'b0, 1'b0, 1'b1);
      4'd4:    u = u_mac(4'd0, 4'd5, 1'b0, 1'b1, 1'b0);
      4'd5:    u = u_ctl(UK_STORE, dst + 4'd1, 2'd0);
      4'd6:    u = u_mac(4'd0, 4'd4, 1'b0, 1'b0, 1'b1);
      4'd7:    u = u_mac(4'd1, 4'd3, 1'b0, 1'b1, 1'b0);
      default: u = u_ctl(UK_STORE, dst + 4'd2, 2'd0);
    endcase
    return u;
  endfunction

  // Edge-relative points: edge 0 is B->C opposite A, edge 1 A->C opposite B,
  // edge 2 A->B opposite C.
  function automatic pt_t pt_resolve(pt_t pt, logic [1:0] edg);
    pt_t r;
    case (pt)
      PT_BASE: r = (edg == 2'd0) ? PT_B : PT_A;
      PT_END:  r = (edg == 2'd2) ? PT_B : PT_C;
      PT_OPP:  r = (edg == 2'd0) ? PT_A : ((edg == 2'd1) ? PT_B : PT_C);
      default: r = pt;
    endcase
    return r;
  endfunction

  // Slots: 0..2 first edge vector, 3..5 second, 6..8 normal or first cross,
  // 9..11 O-A or second cross, 12..14 direction, 15 quotient.
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc) inside
      [7'd0:7'd2]:   u = u_load(4'(pc), PT_B, PT_A, 2'(pc));
      [7'd3:7'd5]:   u = u_load(4'(pc), PT_C, PT_A, 2'(pc - 7'd3));
      [7'd6:7'd8]:   u = u_load(4'(pc + 7'd3), PT_O, PT_A, 2'(pc - 7'd6));
      [7'd9:7'd11]:  u = u_load(4'(pc + 7'd3), PT_D, PT_Z, 2'(pc - 7'd9));
      [7'd12:7'd20]: u = u_cross(4'(pc - 7'd12), 4'd6);
      7'd21:         u = u_mac(4'd6, 4'd9, 1'b0, 1'b0, 1'b1);
      7'd22:         u = u_mac(4'd7, 4'd10, 1'b0, 1'b0, 1'b0);
      7'd23:         u = u_mac(4'd8, 4'd11, 1'b0, 1'b0, 1'b0);
      7'd24:         u = u_ctl(UK_SVNUM, 4'd0, 2'd0);
      7'd25:         u = u_mac(4'd6, 4'd12, 1'b0, 1'b0, 1'b1);
      7'd26:         u = u_mac(4'd7, 4'd13, 1'b0, 1'b0, 1'b0);
      7'd27:         u = u_mac(4'd8, 4'd14, 1'b0, 1'b0, 1'b0);
      7'd28:         u = u_ctl(UK_DIV, 4'd0, 2'd0);
      7'd29:         u = u_mac(4'd12, Q_SLOT, 1'b0, 1'b0, 1'b1);
      7'd30:         u = u_ctl(UK_PNT, 4'd0, 2'd0);
      7'd31:         u = u_mac(4'd13, Q_SLOT, 1'b0, 1'b0, 1'b1);
      7'd32:         u = u_ctl(UK_PNT, 4'd0, 2'd1);
      7'd33:         u = u_mac(4'd14, Q_SLOT, 1'b0, 1'b0, 1'b1);
      7'd34:         u = u_ctl(UK_PNT, 4'd0, 2'd2);
      [7'd35:7'd37]: u = u_load(4'(pc - 7'd35), PT_END, PT_BASE, 2'(pc - 7'd35));
      [7'd38:7'd40]: u = u_load(4'(pc - 7'd35), PT_P, PT_BASE, 2'(pc - 7'd38));
      [7'd41:7'd49]: u = u_cross(4'(pc - 7'd41), 4'd6);
      [7'd50:7'd52]: u = u_load(4'(pc - 7'd47), PT_OPP, PT_BASE, 2'(pc - 7'd50));
      [7'd53:7'd61]: u = u_cross(4'(pc - 7'd53), 4'd9);
      7'd62:         u = u_mac(4'd6, 4'd9, 1'b1, 1'b0, 1'b1);
      7'd63:         u = u_mac(4'd7, 4'd10, 1'b1, 1'b0, 1'b0);
      7'd64:         u = u_mac(4'd8, 4'd11, 1'b1, 1'b0, 1'b0);
      7'd65:         u = u_ctl(UK_SIDE, 4'd0, 2'd0);
      default:       u = u_ctl(UK_HIT, 4'd0, 2'd0);
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/ray_triangle_nearest_hit.sv =====
// Ray/triangle nearest-hit block: sequencer, scratch slots, result and closest-distance state.
// Depends on rtnh_pkg, rtnh_mac and rtnh_div.
//
// Usage. The ray origin and direction are written through the cfg_ port (index 0..2 origin
// x, y, z, 3..5 direction x, y, z, all signed Q16.16) while the block is idle. Each input
// transaction carries one triangle A, B, C on in_tdata and the first-in-pass flag on
// in_tuser; a set flag restarts the running closest distance. Each input transaction
// yields exactly one output transaction: hit distance t/2 (all ones on a miss), the hit
// point (zero unless closer), and on out_tuser whether this triangle is closer than every
// earlier one of the pass.
//
// Timing. in_tready is high only while the block is idle, so one triangle is in work at a
// time. All products run through one bit-serial multiply-accumulate unit (one partial
// product per cycle, 33 steps for coordinate products, 68 for products of cross products),
// and t comes from a one-bit-per-cycle divider. A full hit takes longest from acceptance to
// output; a triangle rejected at the plane test finishes soonest, and one rejected at an
// edge test lies in between.
//
// Reset (rst_n low, synchronous) clears the ray registers to zero, sets the closest
// distance to its maximum and returns the sequencer to idle. When the receiver holds
// out_tready low, the result stays on out_tdata/out_tuser and no new triangle is taken.
`timescale 1ns / 1ps
module ray_triangle_nearest_hit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, 32 bits each
  input  logic [287:0]  in_tdata,
  // first_in_pass
  input  logic [0:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // hit_distance (31), hit_x, hit_y, hit_z (32 each) from bit 0 up, one zero pad bit on top
  output logic [127:0]  out_tdata,
  // closer_hit
  output logic [0:0]    out_tuser,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int CW = rtnh_pkg::CRD_W;

  rtnh_pkg::seq_state_t state_r, state_nxt;
  logic [rtnh_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [1:0]                edge_idx_r, edge_idx_nxt;
  rtnh_pkg::uop_t            op;

  // Ray and triangle storage.
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic signed [CW-1:0] vtx_r [3][3];
  logic signed [CW-1:0] p_r   [3];

  logic [rtnh_pkg::DIST_W-1:0] closest_r;

  // Scratch slots with registered reads.
  logic signed [rtnh_pkg::SLOT_W-1:0] slot_mem [16];
  logic signed [rtnh_pkg::SLOT_W-1:0] rd_a_r, rd_b_r;
  logic                               slot_we;
  logic [rtnh_pkg::SLOT_AW-1:0]       slot_wa;
  logic signed [rtnh_pkg::SLOT_W-1:0] slot_wd;

  logic signed [rtnh_pkg::NUM_W-1:0]  num_r;
  logic                               num_we, pnt_we;

  rtnh_pkg::mac_ctl_t                 mac_ctl;
  rtnh_pkg::mac_sts_t                 mac_sts;
  logic signed [rtnh_pkg::ACC_W-1:0]  acc;

  logic                               div_start, div_done;
  logic [rtnh_pkg::Q_W-1:0]           q;

  // Finish strobe and the distance it reports.
  logic                               fin, closer;
  logic [rtnh_pkg::DIST_W-1:0]        fin_dist;

  rtnh_pkg::pt_t                      pm, ps;
  logic signed [CW-1:0]               mval, sval;
  logic signed [rtnh_pkg::DIFF_W-1:0] ld_diff;
  logic signed [48:0]                 pnt_sum;
  logic signed [CW-1:0]               pnt_sat;
  logic                               den_ok;

  logic                               out_closer_r;
  logic [rtnh_pkg::DIST_W-1:0]        out_dist_r;
  logic signed [CW-1:0]               out_p_r [3];

  logic                               in_acc;

  assign op        = rtnh_pkg::ucode(pc_r);
  assign in_tready = (state_r == rtnh_pkg::SQ_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  rtnh_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (rd_a_r),
    .b     (rd_b_r),
    .sts   (mac_sts),
    .acc   (acc)
  );

  rtnh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (acc[rtnh_pkg::NUM_W-1:0]),
    .done  (div_done),
    .q     (q)
  );

  // Operand selection for slot loads: edge-relative points resolve through the edge index.
  always_comb begin
    pm = rtnh_pkg::pt_resolve(op.pm, edge_idx_r);
    ps = rtnh_pkg::pt_resolve(op.ps, edge_idx_r);
    case (pm)
      rtnh_pkg::PT_A: mval = vtx_r[0][op.comp];
      rtnh_pkg::PT_B: mval = vtx_r[1][op.comp];
      rtnh_pkg::PT_C: mval = vtx_r[2][op.comp];
      rtnh_pkg::PT_P: mval = p_r[op.comp];
      rtnh_pkg::PT_O: mval = org_r[op.comp];
      rtnh_pkg::PT_D: mval = dir_r[op.comp];
      default:        mval = '0;
    endcase
    case (ps)
      rtnh_pkg::PT_A: sval = vtx_r[0][op.comp];
      rtnh_pkg::PT_B: sval = vtx_r[1][op.comp];
      rtnh_pkg::PT_C: sval = vtx_r[2][op.comp];
      rtnh_pkg::PT_P: sval = p_r[op.comp];
      rtnh_pkg::PT_O: sval = org_r[op.comp];
      rtnh_pkg::PT_D: sval = dir_r[op.comp];
      default:        sval = '0;
    endcase
    ld_diff = rtnh_pkg::DIFF_W'(mval) - rtnh_pkg::DIFF_W'(sval);
  end

  // Hit point: origin plus floor(D*t / 2^16), clamped to the signed 32-bit range.
  always_comb begin
    pnt_sum = 49'(org_r[op.comp]) + 49'($signed(acc[63:16]));
    if (pnt_sum[48:31] == '0 || pnt_sum[48:31] == '1) begin
      pnt_sat = pnt_sum[CW-1:0];
    end else if (pnt_sum[48]) begin
      pnt_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      pnt_sat = {1'b0, {(CW-1){1'b1}}};
    end
  end

  // A forward hit needs nonzero numerator and denominator of opposite signs.
  assign den_ok = (acc != '0) && (num_r != '0) &&
                  (num_r[rtnh_pkg::NUM_W-1] != acc[rtnh_pkg::ACC_W-1]);

  assign closer = fin_dist < closest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rtnh_pkg::SQ_IDLE;
      pc_r       <= '0;
      edge_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      edge_idx_r <= edge_idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    edge_idx_nxt = edge_idx_r;
    mac_ctl      = '0;
    div_start    = 1'b0;
    slot_we      = 1'b0;
    slot_wa      = op.dst;
    slot_wd      = '0;
    num_we       = 1'b0;
    pnt_we       = 1'b0;
    fin          = 1'b0;
    fin_dist     = rtnh_pkg::MISS_DIST;
    case (state_r)
      rtnh_pkg::SQ_IDLE: begin
        if (in_tvalid) begin
          state_nxt    = rtnh_pkg::SQ_FETCH;
          pc_nxt       = '0;
          edge_idx_nxt = '0;
        end
      end
      rtnh_pkg::SQ_FETCH: state_nxt = rtnh_pkg::SQ_EXEC;
      rtnh_pkg::SQ_EXEC: begin
        state_nxt = rtnh_pkg::SQ_FETCH;
        pc_nxt    = pc_r + 1'b1;
        case (op.kind)
          rtnh_pkg::UK_LOAD: begin
            slot_we = 1'b1;
            slot_wd = rtnh_pkg::SLOT_W'(ld_diff);
          end
          rtnh_pkg::UK_MAC: begin
            mac_ctl.start = 1'b1;
            mac_ctl.clr   = op.clr;
            mac_ctl.neg   = op.neg;
            mac_ctl.wide  = op.wide;
            pc_nxt        = pc_r;
            state_nxt     = rtnh_pkg::SQ_WAIT;
          end
          rtnh_pkg::UK_STORE: begin
            slot_we = 1'b1;
            slot_wd = acc[rtnh_pkg::SLOT_W-1:0];
          end
          rtnh_pkg::UK_SVNUM: num_we = 1'b1;
          rtnh_pkg::UK_DIV: begin
            pc_nxt = pc_r;
            if (den_ok) begin
              div_start = 1'b1;
              state_nxt = rtnh_pkg::SQ_WAIT;
            end else begin
              fin       = 1'b1;
              state_nxt = rtnh_pkg::SQ_OUT;
            end
          end
          rtnh_pkg::UK_PNT: pnt_we = 1'b1;
          rtnh_pkg::UK_SIDE: begin
            if (acc[rtnh_pkg::ACC_W-1]) begin
              fin       = 1'b1;
              pc_nxt    = pc_r;
              state_nxt = rtnh_pkg::SQ_OUT;
            end else if (edge_idx_r != 2'd2) begin
              edge_idx_nxt = edge_idx_r + 1'b1;
              pc_nxt       = rtnh_pkg::EDGE_PC;
            end
          end
          default: begin
            // Passed every edge test.
            fin       = 1'b1;
            fin_dist  = q >> 1;
            pc_nxt    = pc_r;
            state_nxt = rtnh_pkg::SQ_OUT;
          end
        endcase
      end
      rtnh_pkg::SQ_WAIT: begin
        if (op.kind == rtnh_pkg::UK_DIV) begin
          if (div_done) begin
            slot_we   = 1'b1;
            slot_wa   = rtnh_pkg::Q_SLOT;
            slot_wd   = rtnh_pkg::SLOT_W'(q);
            pc_nxt    = pc_r + 1'b1;
            state_nxt = rtnh_pkg::SQ_FETCH;
          end
        end else if (mac_sts.done) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = rtnh_pkg::SQ_FETCH;
        end
      end
      rtnh_pkg::SQ_OUT: begin
        if (out_tready) begin
          state_nxt = rtnh_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = rtnh_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    rd_a_r <= slot_mem[op.sa];
    rd_b_r <= slot_mem[op.sb];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int v = 0; v < 3; v++) begin
        for (int c = 0; c < 3; c++) begin
          vtx_r[v][c] <= in_tdata[(v * 3 + c) * CW +: CW];
        end
      end
    end
    if (num_we) begin
      num_r <= acc[rtnh_pkg::NUM_W-1:0];
    end
    if (pnt_we) begin
      p_r[op.comp] <= pnt_sat;
    end
    if (fin) begin
      out_closer_r <= closer;
      out_dist_r   <= fin_dist;
      for (int c = 0; c < 3; c++) begin
        out_p_r[c] <= closer ? p_r[c] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closest_r <= rtnh_pkg::MISS_DIST;
    end else if (in_acc && in_tuser[0]) begin
      closest_r <= rtnh_pkg::MISS_DIST;
    end else if (fin && closer) begin
      closest_r <= fin_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        org_r[c] <= '0;
        dir_r[c] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rtnh_pkg::REG_ORIGIN_X: org_r[0] <= cfg_wdata;
        rtnh_pkg::REG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        rtnh_pkg::REG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        rtnh_pkg::REG_DIR_X:    dir_r[0] <= cfg_wdata;
        rtnh_pkg::REG_DIR_Y:    dir_r[1] <= cfg_wdata;
        rtnh_pkg::REG_DIR_Z:    dir_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == rtnh_pkg::SQ_OUT);
  assign out_tuser  = out_closer_r;
  assign out_tdata  = {1'b0, out_p_r[2], out_p_r[1], out_p_r[0], out_dist_r};

  // The block never takes a triangle while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  // A closer result is always a real hit, whose distance is below half range.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_tvalid && out_tuser[0] |-> out_tdata[30] == 1'b0)
    else $error("closer result with a miss-range distance");

  // Between passes the closest distance only moves down.
  assert property (@(posedge clk) disable iff (!rst_n)
                   !in_acc |=> closest_r <= $past(closest_r))
    else $error("closest distance grew without a new pass");

  // The multiplier is never restarted while it is still running.
  assert property (@(posedge clk) disable iff (!rst_n) mac_ctl.start |-> !mac_sts.busy)
    else $error("multiplier started while busy");

endmodule

// ===== hw/rtl/rtnh_mac.sv =====
// Shared bit-serial signed multiply-accumulate unit: one shifted add per cycle.
// Depends on rtnh_pkg.
`timescale 1ns / 1ps
module rtnh_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rtnh_pkg::mac_ctl_t                     ctl,
  input  logic signed [rtnh_pkg::SLOT_W-1:0]     a,
  input  logic signed [rtnh_pkg::SLOT_W-1:0]     b,
  output rtnh_pkg::mac_sts_t                     sts,
  output logic signed [rtnh_pkg::ACC_W-1:0]      acc
);

  logic signed [rtnh_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic        [rtnh_pkg::ACC_W-1:0]  a_sh_r, term;
  logic        [rtnh_pkg::SLOT_W-1:0] b_sh_r;
  logic        [rtnh_pkg::STEP_W-1:0] cnt_r;
  logic                               neg_r, busy_r, done_r, sub;

  // The top bit of the serial operand has negative weight.
  always_comb begin
    term    = b_sh_r[0] ? a_sh_r : '0;
    sub     = (cnt_r == '0) ^ neg_r;
    acc_nxt = acc_r + (sub ? ~term : term) + rtnh_pkg::ACC_W'(sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_sh_r <= rtnh_pkg::ACC_W'(a);
      b_sh_r <= b;
      cnt_r  <= ctl.wide ? rtnh_pkg::WIDE_LAST : rtnh_pkg::NARROW_LAST;
      neg_r  <= ctl.neg;
      if (ctl.clr) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign acc      = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== hw/rtl/rtnh_div.sv =====
// Restoring divider for t = |num| * 2^16 / |den|, one quotient bit per cycle, saturating.
// Depends on rtnh_pkg.
`timescale 1ns / 1ps
module rtnh_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [rtnh_pkg::NUM_W-1:0]    num,
  input  logic signed [rtnh_pkg::NUM_W-1:0]    den,
  output logic                                 done,
  output logic        [rtnh_pkg::Q_W-1:0]      q
);

  rtnh_pkg::div_state_t state_r, state_nxt;
  logic [rtnh_pkg::DIV_W-1:0]  rem_r, s_r, diff;
  logic [rtnh_pkg::NUM_W-1:0]  nmag, dmag;
  logic [rtnh_pkg::Q_W-1:0]    q_r;
  logic [rtnh_pkg::QCNT_W-1:0] cnt_r;
  logic                        ge, done_r, done_nxt;

  always_comb begin
    nmag = num[rtnh_pkg::NUM_W-1] ? rtnh_pkg::NUM_W'(-num) : num;
    dmag = den[rtnh_pkg::NUM_W-1] ? rtnh_pkg::NUM_W'(-den) : den;
    ge   = rem_r >= s_r;
    diff = rem_r - s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtnh_pkg::DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      rtnh_pkg::DV_IDLE: begin
        if (start) begin
          state_nxt = rtnh_pkg::DV_CHK;
        end
      end
      rtnh_pkg::DV_CHK: begin
        if (ge) begin
          state_nxt = rtnh_pkg::DV_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = rtnh_pkg::DV_RUN;
        end
      end
      rtnh_pkg::DV_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = rtnh_pkg::DV_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = rtnh_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rtnh_pkg::DV_IDLE: begin
        if (start) begin
          rem_r <= rtnh_pkg::DIV_W'(nmag) << 16;
          s_r   <= rtnh_pkg::DIV_W'(dmag) << rtnh_pkg::Q_W;
        end
      end
      rtnh_pkg::DV_CHK: begin
        q_r   <= ge ? rtnh_pkg::Q_SAT : '0;
        s_r   <= s_r >> 1;
        cnt_r <= rtnh_pkg::QCNT_W'(rtnh_pkg::Q_W - 1);
      end
      rtnh_pkg::DV_RUN: begin
        if (ge) begin
          rem_r <= diff;
        end
        q_r   <= {q_r[rtnh_pkg::Q_W-2:0], ge};
        s_r   <= s_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
